@@ hw/rtl/cinp_pkg.sv @@
package cinp_pkg;

	typedef enum logic [11:0] {
		PH_PID_LIT  = 12'b0000_0000_0001,
		PH_PID      = 12'b0000_0000_0010,
		PH_LUID_LIT = 12'b0000_0000_0100,
		PH_HI       = 12'b0000_0000_1000,
		PH_SEP_LIT  = 12'b0000_0001_0000,
		PH_LO       = 12'b0000_0010_0000,
		PH_PHYS_LIT = 12'b0000_0100_0000,
		PH_PHYS     = 12'b0000_1000_0000,
		PH_ENG_LIT  = 12'b0001_0000_0000,
		PH_ENG      = 12'b0010_0000_0000,
		PH_TYPE_LIT = 12'b0100_0000_0000,
		PH_TAIL     = 12'b1000_0000_0000
	} phase_t;

	typedef enum logic [2:0] {
		LEAD_START  = 3'b001,
		LEAD_ZERO   = 3'b010,
		LEAD_DIGITS = 3'b100
	} lead_t;

	localparam logic [15:0] CH_ZERO  = 16'h0030;
	localparam logic [15:0] CH_NINE  = 16'h0039;
	localparam logic [15:0] CH_LC_A  = 16'h0061;
	localparam logic [15:0] CH_LC_F  = 16'h0066;
	localparam logic [15:0] CH_UC_A  = 16'h0041;
	localparam logic [15:0] CH_UC_F  = 16'h0046;
	localparam logic [15:0] CH_LC_X  = 16'h0078;
	localparam logic [15:0] CH_UC_X  = 16'h0058;
	localparam logic [15:0] CH_NUL   = 16'h0000;

	localparam int unsigned TDATA_W = 184;

	// one queued transaction: an optional type char followed by an optional record
	typedef struct packed {
		logic        has_char;
		logic [15:0] type_char;
		logic        has_rec;
		logic        ok;
		logic [31:0] pid;
		logic [63:0] luid;
		logic [31:0] phys;
		logic [31:0] eng;
	} cinp_entry_t;

	function automatic phase_t phase_next(input phase_t ph);
		phase_t r;
		unique case (ph)
			PH_PID_LIT:  r = PH_PID;
			PH_PID:      r = PH_LUID_LIT;
			PH_LUID_LIT: r = PH_HI;
			PH_HI:       r = PH_SEP_LIT;
			PH_SEP_LIT:  r = PH_LO;
			PH_LO:       r = PH_PHYS_LIT;
			PH_PHYS_LIT: r = PH_PHYS;
			PH_PHYS:     r = PH_ENG_LIT;
			PH_ENG_LIT:  r = PH_ENG;
			PH_ENG:      r = PH_TYPE_LIT;
			PH_TYPE_LIT: r = PH_TAIL;
			default:     r = PH_TAIL;
		endcase
		return r;
	endfunction

	function automatic logic [3:0] lit_len(input phase_t ph);
		logic [3:0] n;
		unique case (ph)
			PH_PID_LIT:  n = 4'd4;
			PH_LUID_LIT: n = 4'd6;
			PH_SEP_LIT:  n = 4'd1;
			PH_PHYS_LIT: n = 4'd6;
			PH_ENG_LIT:  n = 4'd5;
			PH_TYPE_LIT: n = 4'd9;
			default:     n = 4'd0;
		endcase
		return n;
	endfunction

	function automatic logic [71:0] lit_str(input phase_t ph);
		logic [71:0] s;
		unique case (ph)
			PH_PID_LIT:  s = 72'("pid_");
			PH_LUID_LIT: s = 72'("_luid_");
			PH_SEP_LIT:  s = 72'("_");
			PH_PHYS_LIT: s = 72'("_phys_");
			PH_ENG_LIT:  s = 72'("_eng_");
			PH_TYPE_LIT: s = 72'("_engtype_");
			default:     s = '0;
		endcase
		return s;
	endfunction

	// character at position pos of the literal, first character leftmost
	function automatic logic [7:0] lit_char(input phase_t ph, input logic [3:0] pos);
		logic [71:0] s;
		logic [3:0]  n;
		logic [7:0]  c;
		s = lit_str(ph);
		n = lit_len(ph);
		c = 8'h00;
		if (pos < n) begin
			c = s[8 * (int'(n) - 1 - int'(pos)) +: 8];
		end
		return c;
	endfunction

endpackage

@@ hw/rtl/cinp_parser.sv @@
module cinp_parser import cinp_pkg::*; #(
	parameter int unsigned MAX_TYPE_CHARS = 63
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [15:0] char_code,
	input  logic        end_of_name,
	output cinp_entry_t res
);

	localparam int unsigned TAIL_W = (MAX_TYPE_CHARS < 1) ? 1 : $clog2(MAX_TYPE_CHARS + 1);
	localparam logic [TAIL_W-1:0] TAIL_MAX = TAIL_W'(MAX_TYPE_CHARS);

	phase_t              phase_q, phase_n;
	lead_t               lead_q, lead_n;
	logic [3:0]          pos_q, pos_n;
	logic [31:0]         acc_q, acc_n;
	logic                seen_q, seen_n;
	logic                failed_q, failed_n;
	logic [31:0]         pid_q, pid_n;
	logic [31:0]         hi_q, hi_n;
	logic [31:0]         lo_q, lo_n;
	logic [31:0]         phys_q, phys_n;
	logic [31:0]         eng_q, eng_n;
	logic [TAIL_W-1:0]   tail_q, tail_n;

	logic        is_dec, is_lc, is_uc, hex_ok;
	logic [3:0]  hex_d;
	logic [35:0] dec_sum;
	logic        field_close, lit_check, hexdig, seen_eff, ok;
	phase_t      lit_ph;
	logic [3:0]  lit_pos;

	assign is_dec  = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
	assign is_lc   = (char_code >= CH_LC_A) && (char_code <= CH_LC_F);
	assign is_uc   = (char_code >= CH_UC_A) && (char_code <= CH_UC_F);
	assign hex_ok  = is_dec || is_lc || is_uc;
	assign hex_d   = is_dec ? char_code[3:0] : (char_code[3:0] + 4'd9);
	assign dec_sum = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {32'd0, char_code[3:0]};

	always_comb begin
		phase_n     = phase_q;
		lead_n      = lead_q;
		pos_n       = pos_q;
		acc_n       = acc_q;
		seen_n      = seen_q;
		failed_n    = failed_q;
		pid_n       = pid_q;
		hi_n        = hi_q;
		lo_n        = lo_q;
		phys_n      = phys_q;
		eng_n       = eng_q;
		tail_n      = tail_q;
		field_close = 1'b0;
		lit_check   = 1'b0;
		hexdig      = 1'b0;
		seen_eff    = seen_q;
		lit_ph      = phase_q;
		lit_pos     = pos_q;
		ok          = 1'b0;
		res         = '0;

		if (!failed_q) begin
			unique case (phase_q)
				PH_TAIL: begin
					if (char_code == CH_NUL) begin
						tail_n = TAIL_MAX;
					end else if (tail_q < TAIL_MAX) begin
						tail_n        = tail_q + 1'b1;
						res.has_char  = 1'b1;
						res.type_char = char_code;
					end
				end
				PH_PID_LIT, PH_LUID_LIT, PH_SEP_LIT, PH_PHYS_LIT, PH_ENG_LIT,
				PH_TYPE_LIT: begin
					lit_check = 1'b1;
				end
				PH_HI, PH_LO: begin
					unique case (lead_q)
						LEAD_START: begin
							if (char_code == CH_ZERO) begin
								lead_n = LEAD_ZERO;
							end else begin
								lead_n = LEAD_DIGITS;
								hexdig = 1'b1;
							end
						end
						LEAD_ZERO: begin
							lead_n = LEAD_DIGITS;
							if (char_code != CH_LC_X && char_code != CH_UC_X) begin
								seen_n   = 1'b1;
								seen_eff = 1'b1;
								hexdig   = 1'b1;
							end
						end
						LEAD_DIGITS: begin
							hexdig = 1'b1;
						end
						default: begin
							failed_n = 1'b1;
						end
					endcase
				end
				PH_PID, PH_PHYS, PH_ENG: begin
					if (is_dec) begin
						if (dec_sum[35:32] != 4'd0) begin
							failed_n = 1'b1;
						end else begin
							acc_n  = dec_sum[31:0];
							seen_n = 1'b1;
						end
					end else begin
						field_close = 1'b1;
					end
				end
				default: begin
					failed_n = 1'b1;
				end
			endcase

			if (hexdig) begin
				if (hex_ok) begin
					if (acc_q[31:28] != 4'd0) begin
						failed_n = 1'b1;
					end else begin
						acc_n  = {acc_q[27:0], hex_d};
						seen_n = 1'b1;
					end
				end else begin
					field_close = 1'b1;
				end
			end

			if (field_close) begin
				if (!seen_eff) begin
					failed_n = 1'b1;
				end else begin
					unique case (phase_q)
						PH_PID:  pid_n  = acc_q;
						PH_HI:   hi_n   = acc_q;
						PH_LO:   lo_n   = acc_q;
						PH_PHYS: phys_n = acc_q;
						default: eng_n  = acc_q;
					endcase
					lit_check = 1'b1;
					lit_ph    = phase_next(phase_q);
					lit_pos   = 4'd0;
					phase_n   = lit_ph;
					pos_n     = 4'd0;
				end
			end

			if (lit_check) begin
				if (lit_pos >= lit_len(lit_ph) ||
				    char_code != {8'h00, lit_char(lit_ph, lit_pos)}) begin
					failed_n = 1'b1;
				end else if (lit_pos + 4'd1 == lit_len(lit_ph)) begin
					phase_n = phase_next(lit_ph);
					pos_n   = 4'd0;
					acc_n   = '0;
					seen_n  = 1'b0;
					lead_n  = LEAD_START;
				end else begin
					pos_n = lit_pos + 4'd1;
				end
			end
		end

		if (end_of_name) begin
			ok          = !failed_n && (phase_n == PH_TAIL);
			res.has_rec = 1'b1;
			res.ok      = ok;
			res.pid     = ok ? pid_n : '0;
			res.luid    = ok ? {hi_n, lo_n} : '0;
			res.phys    = ok ? phys_n : '0;
			res.eng     = ok ? eng_n : '0;
			phase_n     = PH_PID_LIT;
			lead_n      = LEAD_START;
			pos_n       = '0;
			acc_n       = '0;
			seen_n      = 1'b0;
			failed_n    = 1'b0;
			pid_n       = '0;
			hi_n        = '0;
			lo_n        = '0;
			phys_n      = '0;
			eng_n       = '0;
			tail_n      = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_PID_LIT;
			lead_q   <= LEAD_START;
			pos_q    <= '0;
			acc_q    <= '0;
			seen_q   <= 1'b0;
			failed_q <= 1'b0;
			pid_q    <= '0;
			hi_q     <= '0;
			lo_q     <= '0;
			phys_q   <= '0;
			eng_q    <= '0;
			tail_q   <= '0;
		end else if (step) begin
			phase_q  <= phase_n;
			lead_q   <= lead_n;
			pos_q    <= pos_n;
			acc_q    <= acc_n;
			seen_q   <= seen_n;
			failed_q <= failed_n;
			pid_q    <= pid_n;
			hi_q     <= hi_n;
			lo_q     <= lo_n;
			phys_q   <= phys_n;
			eng_q    <= eng_n;
			tail_q   <= tail_n;
		end
	end

endmodule

@@ hw/rtl/counter_instance_name_parser_top.sv @@
// each result is written to the result queue when its input is accepted and is offered from the queue
// throughput: one character per cycle while the result queue has room; a final character that also
// echoes a type character holds its queue slot until both results leave
// the parser state updates once per accepted character; a two-entry result queue decouples the sides
// reset: arst_n clears the parser to the start of a name and empties the result queue
module counter_instance_name_parser_top import cinp_pkg::*; #(
	parameter int unsigned MAX_TYPE_CHARS = 63
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [15:0]        s_axis_tdata,  // char_code
	input  logic               s_axis_tlast,
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	// type_char, parse_ok, process_id, adapter_luid, physical_index, engine_number, zero pad
	output logic [TDATA_W-1:0] m_axis_tdata,
	output logic               m_axis_tuser,  // result_kind
	output logic               m_axis_tlast
);

	localparam int unsigned DEPTH = 2;

	cinp_entry_t step_res;
	cinp_entry_t queue_q [DEPTH];
	cinp_entry_t head;
	logic        wptr_q, rptr_q;
	logic [1:0]  cnt_q;
	logic        char_done_q;
	logic        s_fire, m_fire, push, pop, out_is_char;

	assign s_fire = s_axis_tvalid && s_axis_tready;
	assign m_fire = m_axis_tvalid && m_axis_tready;

	cinp_parser #(
		.MAX_TYPE_CHARS(MAX_TYPE_CHARS)
	) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (s_fire),
		.char_code  (s_axis_tdata),
		.end_of_name(s_axis_tlast),
		.res        (step_res)
	);

	assign head          = queue_q[rptr_q];
	assign out_is_char   = head.has_char && !char_done_q;
	assign push          = s_fire && (step_res.has_char || step_res.has_rec);
	assign pop           = m_fire && (!out_is_char || !head.has_rec);
	assign s_axis_tready = (cnt_q < 2'(DEPTH));
	assign m_axis_tvalid = (cnt_q != 2'd0);
	assign m_axis_tuser  = !out_is_char;
	assign m_axis_tlast  = !out_is_char || !head.has_rec;

	always_comb begin
		m_axis_tdata = '0;
		if (out_is_char) begin
			m_axis_tdata[15:0] = head.type_char;
		end else begin
			m_axis_tdata[16]      = head.ok;
			m_axis_tdata[48:17]   = head.pid;
			m_axis_tdata[112:49]  = head.luid;
			m_axis_tdata[144:113] = head.phys;
			m_axis_tdata[176:145] = head.eng;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wptr_q] <= step_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q      <= 1'b0;
			rptr_q      <= 1'b0;
			cnt_q       <= '0;
			char_done_q <= 1'b0;
		end else begin
			if (push) begin
				wptr_q <= !wptr_q;
			end
			if (pop) begin
				rptr_q <= !rptr_q;
			end
			if (m_fire) begin
				char_done_q <= !pop;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'(DEPTH))
		else $error("result queue count out of range");

	a_record_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
		else $error("record without tlast");

	a_char_then_record: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid && m_axis_tuser)
		else $error("type char without tlast not followed by a record");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser && !m_axis_tdata[16] |-> m_axis_tdata == '0)
		else $error("failed record carries nonzero fields");
`endif

endmodule
